/* rtl/core/mwss_pkg.sv */
// Shared types and codes of the Markov weighted symbol sampler.
// No dependencies; used by the sampler core, its scale unit and its checker.
package mwss_pkg;

	localparam int unsigned SymW   = 5;
	localparam int unsigned CfgW   = 6;
	localparam int unsigned TotalW = 64;
	localparam int unsigned CountW = 32;
	localparam int unsigned FracW  = 32;

	typedef enum logic [1:0] {
		CMD_LOAD_TOTAL = 2'd0,
		CMD_LOAD_COUNT = 2'd1,
		CMD_DRAW       = 2'd2,
		CMD_RESTART    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [SymW-1:0]    ctx_first;
		logic [SymW-1:0]    ctx_second;
		logic [SymW-1:0]    next_symbol;
		logic [TotalW-1:0]  load_value;
		logic [FracW-1:0]   random_fraction;
	} in_t;

	typedef struct packed {
		logic [SymW-1:0] symbol;
		logic            ran_past_end;
	} out_t;

endpackage

/* rtl/core/markov_weighted_symbol_sampler_unit.sv */
// Markov weighted symbol sampler, top level.
// Load and restart transactions complete at acceptance.
// Draw: S_TOT, S_SCALE, then S_WALK over w = counts walked (1..k); result registered
//   when the walk finishes and the result register is free, next item taken in S_IDLE;
//   paced by the count memory walk (one count per cycle) and the two-pass scale.
// Reset: async active low; history = boundary symbol, symbols_in_use = 32.
//   Total and count memories are not cleared.
module markov_weighted_symbol_sampler_unit #(
	parameter int unsigned MAX_SYMBOLS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mwss_pkg::in_t               in_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output mwss_pkg::out_t              out_data,
	// configuration: symbols_in_use
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mwss_pkg::CfgW-1:0]   cfg_data
);

	// symbol index width and memory geometry follow the alphabet capacity
	localparam int unsigned SW      = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int unsigned TOT_AW  = 2 * SW;
	localparam int unsigned CNT_AW  = 3 * SW;
	localparam logic [6:0]  MAX7    = 7'(MAX_SYMBOLS);
	// boundary symbol for the reset value of symbols_in_use (32, clamped)
	localparam logic [SW-1:0] RST_LAST = SW'(((MAX_SYMBOLS < 32) ? MAX_SYMBOLS : 32) - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,  // take items; loads and restart finish here
		S_TOT   = 4'b0010,  // context total read data valid, start scale
		S_SCALE = 4'b0100,  // wait for scaled n
		S_WALK  = 4'b1000   // one count compared per cycle
	} state_t;

	state_t state_q, state_d;

	// ---------------------------------------------------------------------
	// configuration and alphabet clamp
	// ---------------------------------------------------------------------
	logic [mwss_pkg::CfgW-1:0] sym_cfg_q;
	logic [SW-1:0]             k_last;      // last symbol in use, clamp(size)-1

	assign cfg_ready = 1'b1;

	always_comb begin
		priority if (sym_cfg_q < 6'd2) begin
			k_last = SW'(1);
		end else if ({1'b0, sym_cfg_q} > MAX7) begin
			k_last = SW'(MAX_SYMBOLS - 1);
		end else begin
			k_last = SW'(sym_cfg_q - 6'd1);
		end
	end

	// ---------------------------------------------------------------------
	// input decode
	// ---------------------------------------------------------------------
	logic          in_acc;
	logic          a_ok, b_ok, nx_ok;
	logic [SW-1:0] a_ix, b_ix, nx_ix;
	logic          tot_we, cnt_we, draw_acc, restart_acc;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// loads whose indexes fall outside the capacity are dropped
	assign a_ok  = {2'b0, in_data.ctx_first}   < MAX7;
	assign b_ok  = {2'b0, in_data.ctx_second}  < MAX7;
	assign nx_ok = {2'b0, in_data.next_symbol} < MAX7;
	assign a_ix  = SW'(in_data.ctx_first);
	assign b_ix  = SW'(in_data.ctx_second);
	assign nx_ix = SW'(in_data.next_symbol);

	assign tot_we      = in_acc && (in_data.cmd == mwss_pkg::CMD_LOAD_TOTAL) && a_ok && b_ok;
	assign cnt_we      = in_acc && (in_data.cmd == mwss_pkg::CMD_LOAD_COUNT)
	                     && a_ok && b_ok && nx_ok;
	assign draw_acc    = in_acc && (in_data.cmd == mwss_pkg::CMD_DRAW);
	assign restart_acc = in_acc && (in_data.cmd == mwss_pkg::CMD_RESTART);

	// ---------------------------------------------------------------------
	// history and memories
	// ---------------------------------------------------------------------
	logic [SW-1:0]             older_q, newer_q;
	logic [SW-1:0]             rd_sym_q;      // next count address to read
	logic [SW-1:0]             walk_q;        // symbol under compare
	logic [SW-1:0]             cnt_rd_sym;
	logic                      cnt_rd_en;
	logic [63:0]               tot_mem [2**TOT_AW];
	logic [31:0]               cnt_mem [2**CNT_AW];
	logic [63:0]               tot_rdata;
	logic [31:0]               cnt_rdata;

	// a draw reads its context total at acceptance; history is stable then,
	// and any earlier load is already written since items run one at a time
	always_ff @(posedge clk) begin
		if (tot_we) tot_mem[{a_ix, b_ix}] <= in_data.load_value;
		if (draw_acc) tot_rdata <= tot_mem[{older_q, newer_q}];
	end

	// counts are fetched one ahead of the compare; reads past the winner
	// are harmless, read data holds while a finished result waits
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[{a_ix, b_ix, nx_ix}] <= in_data.load_value[31:0];
		if (cnt_rd_en) cnt_rdata <= cnt_mem[{older_q, newer_q, cnt_rd_sym}];
	end

	// ---------------------------------------------------------------------
	// scale unit
	// ---------------------------------------------------------------------
	logic [31:0] frac_q;
	logic        scale_start, scale_done;
	logic [63:0] scale_n;

	mwss_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.total  (tot_rdata),
		.frac   (frac_q),
		.done   (scale_done),
		.n      (scale_n)
	);

	// ---------------------------------------------------------------------
	// walk datapath
	// ---------------------------------------------------------------------
	logic [63:0]   n_q;
	logic [63:0]   m64;
	logic          take, at_last, finish, out_free, hold;
	logic [SW-1:0] res_sym;

	assign m64      = {32'b0, cnt_rdata};
	assign take     = m64 > n_q;
	assign at_last  = (walk_q == k_last);
	assign finish   = (state_q == S_WALK) && (take || at_last);
	assign out_free = !out_valid || !out_stall;
	assign hold     = finish && !out_free;   // result register still full
	assign res_sym  = take ? walk_q : k_last;

	assign scale_start = (state_q == S_TOT);
	assign cnt_rd_en   = ((state_q == S_SCALE) && scale_done) || ((state_q == S_WALK) && !hold);
	assign cnt_rd_sym  = (state_q == S_SCALE) ? '0 : rd_sym_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (draw_acc) state_d = S_TOT;
			end
			S_TOT: begin
				state_d = S_SCALE;
			end
			S_SCALE: begin
				if (scale_done) state_d = S_WALK;
			end
			S_WALK: begin
				if (finish && out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------------
	logic           out_valid_q;
	mwss_pkg::out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sym_cfg_q   <= 6'd32;
			older_q     <= RST_LAST;
			newer_q     <= RST_LAST;
			rd_sym_q    <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) sym_cfg_q <= cfg_data;
			if (restart_acc) begin
				older_q <= k_last;
				newer_q <= k_last;
			end
			if ((state_q == S_SCALE) && scale_done) begin
				rd_sym_q <= SW'(1);
				walk_q   <= '0;
			end else if ((state_q == S_WALK) && !finish) begin
				rd_sym_q <= rd_sym_q + SW'(1);
				walk_q   <= walk_q + SW'(1);
			end
			if (finish && out_free) begin
				older_q     <= newer_q;
				newer_q     <= res_sym;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (draw_acc) frac_q <= in_data.random_fraction;
		if ((state_q == S_SCALE) && scale_done) begin
			n_q <= scale_n;
		end else if ((state_q == S_WALK) && !finish) begin
			n_q <= n_q - m64;
		end
		if (finish && out_free) begin
			out_q.symbol       <= mwss_pkg::SymW'(res_sym);
			out_q.ran_past_end <= !take;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* rtl/core/mwss_scale.sv */
// Two-pass 64x32 fractional scale: n = (total * frac) >> 32, exact.
// Depends on mwss_pkg. One shared 32x32 multiplier; phases: low product, high product, final add, done.
module mwss_scale (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mwss_pkg::TotalW-1:0]  total,
	input  logic [mwss_pkg::FracW-1:0]   frac,
	output logic                         done,
	output logic [mwss_pkg::TotalW-1:0]  n
);

	logic [1:0]  phase_q;   // [0]: high product pass, [1]: final add
	logic        done_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [63:0] n_q;
	logic [31:0] mul_a;
	logic [63:0] prod;

	// low half on the start cycle, high half on the next
	assign mul_a = phase_q[0] ? total[63:32] : total[31:0];
	assign prod  = {32'b0, mul_a} * {32'b0, frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'b00;
			done_q  <= 1'b0;
		end else begin
			phase_q <= {phase_q[0], start};
			done_q  <= phase_q[1];
		end
	end

	always_ff @(posedge clk) begin
		if (start) lo_q <= prod;
		if (phase_q[0]) hi_q <= prod;
		if (phase_q[1]) n_q <= hi_q + {32'b0, lo_q[63:32]};
	end

	assign done = done_q;
	assign n    = n_q;

endmodule

/* rtl/core/mwss_checker.sv */
// Port-level checker for the Markov weighted symbol sampler, bound to the top.
// Depends on mwss_pkg and markov_weighted_symbol_sampler_unit.
module mwss_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input mwss_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input mwss_pkg::out_t out_data
);

	// a draw keeps the item channel stalled after its acceptance
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.cmd == mwss_pkg::CMD_DRAW) |=> in_stall)
		else $error("draw transaction did not hold off the next item");

	// loads and restart complete in their acceptance cycle
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.cmd != mwss_pkg::CMD_DRAW) |=> !in_stall)
		else $error("non-draw transaction blocked the item channel");

	// a new result only comes out of a draw in progress
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a draw in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed or dropped");

endmodule

bind markov_weighted_symbol_sampler_unit mwss_checker u_mwss_checker (.*);

/* test/markov_weighted_symbol_sampler_unit_test.sv */
// Self-checking testbench for markov_weighted_symbol_sampler_unit: loads, draws, restarts and
// alphabet settings, with random idling on both channels and a built-in sampler predictor.
// Depends on rtl/core/mwss_pkg.sv and rtl/core/markov_weighted_symbol_sampler_unit.sv.
`timescale 1ns / 100ps

module markov_weighted_symbol_sampler_unit_test;

	localparam int unsigned MAX_SYM       = 32;
	localparam int unsigned RESET_CYCLES  = 7;
	// Longest draw is at 32 symbols; wait longer than that before touching the register.
	localparam int unsigned SETTLE_CYCLES = 45;
	localparam int unsigned DRAIN_CYCLES  = 200;
	localparam int unsigned MAX_IDLE      = 18;
	localparam int unsigned ITEM_TARGET   = 820;
	// Receiver holds off this long once, so the block fills and stalls its input.
	localparam int unsigned FILL_AT       = 40;
	localparam int unsigned FILL_HOLD     = 1000;
	localparam int unsigned LIMIT_CYCLES  = 600000;

	// Two copies of the sampler state: one steers stimulus planning, one checks the DUT.
	localparam int unsigned PLAN  = 0;
	localparam int unsigned CHECK = 1;

	typedef enum bit {
		ENTRY_ITEM,
		ENTRY_ALPHABET
	} entry_kind_t;

	typedef struct packed {
		entry_kind_t                 kind;
		logic [mwss_pkg::CfgW-1:0]   alphabet;
		mwss_pkg::in_t               item;
	} stimulus_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	mwss_pkg::in_t             in_data   = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	mwss_pkg::out_t            out_data;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [mwss_pkg::CfgW-1:0] cfg_data  = '0;

	markov_weighted_symbol_sampler_unit #(
		.MAX_SYMBOLS(MAX_SYM)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Sampler state, two copies (PLAN / CHECK)
	// ------------------------------------------------------------------
	logic [mwss_pkg::TotalW-1:0] totals_by_ctx     [2][MAX_SYM*MAX_SYM];
	logic [mwss_pkg::CountW-1:0] counts_by_triple  [2][MAX_SYM*MAX_SYM*MAX_SYM];
	logic [mwss_pkg::SymW-1:0]   older_sym         [2];
	logic [mwss_pkg::SymW-1:0]   newer_sym         [2];
	logic [mwss_pkg::CfgW-1:0]   alphabet_reg      [2];

	// Planner bookkeeping: which store entries hold a written value.
	bit                total_loaded [MAX_SYM*MAX_SYM];
	bit                count_loaded [MAX_SYM*MAX_SYM*MAX_SYM];
	logic [MAX_SYM-1:0] favored_syms;

	stimulus_t      pending_items [$];
	mwss_pkg::out_t expected_draws [$];
	int unsigned items_planned  = 0;
	int unsigned draws_planned  = 0;
	int unsigned items_accepted = 0;
	int unsigned alphabet_writes = 0;
	int unsigned results_seen   = 0;
	int unsigned past_end_seen  = 0;
	int unsigned failures       = 0;
	int unsigned cycle_count    = 0;

	// Register value clamped to 2..MAX_SYM.
	function automatic int unsigned alphabet_size(input logic [mwss_pkg::CfgW-1:0] setting);
		if (setting < 2)
			return 2;
		if (setting > MAX_SYM)
			return MAX_SYM;
		return setting;
	endfunction

	// One item applied to one copy of the state; returns the drawn symbol when there is one.
	function automatic void sample_step(input int unsigned who, input mwss_pkg::in_t it,
			output bit produced, output mwss_pkg::out_t drawn);
		logic [9:0]                  ctx;
		logic [95:0]                 wide_total;
		logic [95:0]                 wide_frac;
		logic [95:0]                 scaled;
		logic [mwss_pkg::TotalW-1:0] remaining;
		logic [mwss_pkg::CountW-1:0] weight;
		logic [5:0]                  sym;
		logic [5:0]                  s;
		logic [5:0]                  last_sym;
		bit                          hit;
		int unsigned                 k;
		k = alphabet_size(alphabet_reg[who]);
		last_sym = 6'(k - 1);
		produced = 1'b0;
		drawn = '0;
		case (it.cmd)
			mwss_pkg::CMD_LOAD_TOTAL: begin
				totals_by_ctx[who][{it.ctx_first, it.ctx_second}] = it.load_value;
			end
			mwss_pkg::CMD_LOAD_COUNT: begin
				counts_by_triple[who][{it.ctx_first, it.ctx_second, it.next_symbol}] =
					it.load_value[mwss_pkg::CountW-1:0];
			end
			mwss_pkg::CMD_RESTART: begin
				older_sym[who] = last_sym[mwss_pkg::SymW-1:0];
				newer_sym[who] = last_sym[mwss_pkg::SymW-1:0];
			end
			default: begin
				ctx = {older_sym[who], newer_sym[who]};
				wide_total = {32'd0, totals_by_ctx[who][ctx]};
				wide_frac = {64'd0, it.random_fraction};
				scaled = wide_total * wide_frac;
				remaining = scaled[95:32];
				// walk counts from symbol 0 until one exceeds what is left
				sym = '0;
				hit = 1'b0;
				for (s = '0; s < MAX_SYM; s++) begin
					if (!hit && s < k) begin
						weight = counts_by_triple[who][{ctx, s[mwss_pkg::SymW-1:0]}];
						if ({32'd0, weight} > remaining)
							hit = 1'b1;
						else begin
							remaining = remaining - {32'd0, weight};
							sym = sym + 6'd1;
						end
					end
				end
				if (!hit)
					sym = last_sym;
				older_sym[who] = newer_sym[who];
				newer_sym[who] = sym[mwss_pkg::SymW-1:0];
				drawn.symbol = sym[mwss_pkg::SymW-1:0];
				drawn.ran_past_end = !hit;
				produced = 1'b1;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	function automatic mwss_pkg::in_t random_fields();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(mwss_pkg::in_t)-1:0];
	endfunction

	function automatic void push_item(input mwss_pkg::in_t it);
		bit             produced;
		mwss_pkg::out_t ignored;
		sample_step(PLAN, it, produced, ignored);
		if (it.cmd == mwss_pkg::CMD_LOAD_TOTAL)
			total_loaded[{it.ctx_first, it.ctx_second}] = 1'b1;
		if (it.cmd == mwss_pkg::CMD_LOAD_COUNT)
			count_loaded[{it.ctx_first, it.ctx_second, it.next_symbol}] = 1'b1;
		if (it.cmd == mwss_pkg::CMD_DRAW)
			draws_planned++;
		pending_items.push_back({ENTRY_ITEM, {mwss_pkg::CfgW{1'b0}}, it});
		items_planned++;
	endfunction

	function automatic void push_load(input mwss_pkg::cmd_t cmd, input logic [9:0] ctx,
			input logic [mwss_pkg::SymW-1:0] nx, input logic [mwss_pkg::TotalW-1:0] value);
		mwss_pkg::in_t it;
		it = random_fields();
		it.cmd = cmd;
		{it.ctx_first, it.ctx_second} = ctx;
		if (cmd == mwss_pkg::CMD_LOAD_COUNT)
			it.next_symbol = nx;
		it.load_value = value;
		push_item(it);
	endfunction

	function automatic void push_command(input mwss_pkg::cmd_t cmd,
			input logic [mwss_pkg::FracW-1:0] frac);
		mwss_pkg::in_t it;
		it = random_fields();
		it.cmd = cmd;
		it.random_fraction = frac;
		push_item(it);
	endfunction

	function automatic void plan_alphabet(input logic [mwss_pkg::CfgW-1:0] setting);
		alphabet_reg[PLAN] = setting;
		pending_items.push_back({ENTRY_ALPHABET, setting, mwss_pkg::in_t'('0)});
	endfunction

	// Favored symbols get real weight, the rest mostly zero, so draws stay in few contexts.
	function automatic logic [mwss_pkg::CountW-1:0] pick_count(
			input logic [mwss_pkg::SymW-1:0] sym);
		if (favored_syms[sym]) begin
			case ($urandom_range(7, 0))
				0: return '1;
				1: return $urandom;
				default: return $urandom_range(1000, 1);
			endcase
		end
		return ($urandom_range(5, 0) == 0) ? $urandom_range(50, 1) : '0;
	endfunction

	// Sum of the counts written so far in one context.
	function automatic logic [mwss_pkg::TotalW-1:0] context_sum(input logic [9:0] ctx);
		logic [mwss_pkg::TotalW-1:0] sum;
		logic [5:0]                  s;
		sum = '0;
		for (s = '0; s < alphabet_size(alphabet_reg[PLAN]); s++)
			if (count_loaded[{ctx, s[mwss_pkg::SymW-1:0]}])
				sum = sum + counts_by_triple[PLAN][{ctx, s[mwss_pkg::SymW-1:0]}];
		return sum;
	endfunction

	// Exact sum runs past the end only on all-zero counts; others do some of the time.
	function automatic logic [mwss_pkg::TotalW-1:0] pick_total(
			input logic [mwss_pkg::TotalW-1:0] sum);
		case ($urandom_range(9, 0))
			0: return '1;
			1: return '0;
			2: return {$urandom, $urandom};
			3: return sum + $urandom_range(2000, 1);
			default: return sum;
		endcase
	endfunction

	function automatic logic [mwss_pkg::FracW-1:0] pick_fraction();
		case ($urandom_range(15, 0))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Draw from the current context, loading first whatever the walk could read.
	function automatic void plan_draw(input logic [mwss_pkg::FracW-1:0] frac);
		logic [9:0] ctx;
		logic [5:0] s;
		ctx = {older_sym[PLAN], newer_sym[PLAN]};
		for (s = '0; s < alphabet_size(alphabet_reg[PLAN]); s++)
			if (!count_loaded[{ctx, s[mwss_pkg::SymW-1:0]}])
				push_load(mwss_pkg::CMD_LOAD_COUNT, ctx, s[mwss_pkg::SymW-1:0],
					{$urandom, pick_count(s[mwss_pkg::SymW-1:0])});
		if (!total_loaded[ctx])
			push_load(mwss_pkg::CMD_LOAD_TOTAL, ctx, '0, pick_total(context_sum(ctx)));
		push_command(mwss_pkg::CMD_DRAW, frac);
	endfunction

	function automatic void plan_random_op();
		int unsigned   pick;
		mwss_pkg::in_t it;
		pick = $urandom_range(99, 0);
		if (pick < 70)
			plan_draw(pick_fraction());
		else if (pick < 80)
			push_command(mwss_pkg::CMD_RESTART, $urandom);
		else if (pick < 88)
			push_load(mwss_pkg::CMD_LOAD_TOTAL, {older_sym[PLAN], newer_sym[PLAN]}, '0,
				pick_total(context_sum({older_sym[PLAN], newer_sym[PLAN]})));
		else begin
			// stray load anywhere in the stores
			it = random_fields();
			it.cmd = (pick < 95) ? mwss_pkg::CMD_LOAD_COUNT : mwss_pkg::CMD_LOAD_TOTAL;
			push_item(it);
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: item and register channels
	// ------------------------------------------------------------------
	int unsigned send_gap   = 0;
	int unsigned quiet_cycles = 0;
	bit          tx_eager   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		bit             took_item;
		bit             took_cfg;
		bit             produced;
		bit             next_valid;
		bit             next_cfg;
		mwss_pkg::out_t predicted;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cfg_valid <= 1'b0;
			send_gap = 0;
			quiet_cycles = 0;
		end else begin
			took_item = in_valid && !in_stall;
			took_cfg  = cfg_valid && cfg_ready;
			if (took_item) begin
				sample_step(CHECK, in_data, produced, predicted);
				items_accepted++;
				if (produced)
					expected_draws.push_back(predicted);
			end
			if (took_cfg) begin
				alphabet_reg[CHECK] = cfg_data;
				alphabet_writes++;
			end
			// an offer still waiting keeps its payload untouched
			if (!((in_valid && !took_item) || (cfg_valid && !took_cfg))) begin
				next_valid = 1'b0;
				next_cfg = 1'b0;
				if (send_gap != 0)
					send_gap--;
				else if (pending_items.size() != 0) begin
					if (pending_items[0].kind == ENTRY_ALPHABET) begin
						// register write waits for a drained, quiet block; this
						// is also where the sender pauses for all results
						if (quiet_cycles >= SETTLE_CYCLES) begin
							next_cfg = 1'b1;
							cfg_data <= pending_items[0].alphabet;
							void'(pending_items.pop_front());
						end
					end else begin
						next_valid = 1'b1;
						in_data <= pending_items[0].item;
						void'(pending_items.pop_front());
						if ($urandom_range(29, 0) == 0)
							tx_eager = !tx_eager;
						send_gap = tx_eager ? 0 : $urandom_range(MAX_IDLE, 0);
					end
				end
				in_valid  <= next_valid;
				cfg_valid <= next_cfg;
			end
			if (expected_draws.size() == 0 && !in_valid && !cfg_valid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
		end
	end

	// ------------------------------------------------------------------
	// Long receiver hold, counted in cycles
	// ------------------------------------------------------------------
	int unsigned fill_seen  = 0;
	int unsigned fill_left  = 0;
	bit          fill_done  = 1'b0;
	bit          fill_hold  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_hold <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				fill_seen++;
			if (!fill_done && fill_seen >= FILL_AT) begin
				fill_done = 1'b1;
				fill_left = FILL_HOLD;
			end
			if (fill_left != 0)
				fill_left--;
			fill_hold <= (fill_left != 0);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: result channel, stall pacing and result check
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;
	bit          rx_eager   = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		mwss_pkg::out_t wanted;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (out_data.ran_past_end)
					past_end_seen++;
				if (expected_draws.size() == 0) begin
					$display("%0t: draw result with none pending: symbol %0d flag %0b",
						$time, out_data.symbol, out_data.ran_past_end);
					failures++;
				end else begin
					wanted = expected_draws.pop_front();
					if (out_data.symbol !== wanted.symbol) begin
						$display("%0t: symbol expected %0d actual %0d",
							$time, wanted.symbol, out_data.symbol);
						failures++;
					end
					if (out_data.ran_past_end !== wanted.ran_past_end) begin
						$display("%0t: ran_past_end expected %0b actual %0b",
							$time, wanted.ran_past_end, out_data.ran_past_end);
						failures++;
					end
				end
				if ($urandom_range(29, 0) == 0)
					rx_eager = !rx_eager;
				stall_left = rx_eager ? 0 : $urandom_range(MAX_IDLE, 0);
			end
			if (fill_hold) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= 1'b0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("markov_weighted_symbol_sampler_unit: mismatch");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	logic [mwss_pkg::CfgW-1:0] extreme_settings [5] = '{6'd32, 6'd2, 6'd63, 6'd1, 6'd33};

	initial begin
		int unsigned               phase;
		int unsigned               ops;
		logic [mwss_pkg::CfgW-1:0] setting;
		for (int w = PLAN; w <= CHECK; w++) begin
			older_sym[w] = '1;
			newer_sym[w] = '1;
			alphabet_reg[w] = 6'd32;
		end
		favored_syms = '0;

		// Directed: zero setting clamps to two symbols while history is still 31,31
		// (history beyond the alphabet, top context indexes).
		plan_alphabet(6'd0);
		push_load(mwss_pkg::CMD_LOAD_TOTAL, {5'd31, 5'd31}, '0, 64'd100);
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd31, 5'd31}, 5'd0, {32'hFFFF_FFFF, 32'd40});
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd31, 5'd31}, 5'd1, 64'd60);
		plan_draw('0);
		// restart -> boundary 1,1; full-scale total and count, all-ones draw runs past the end
		push_command(mwss_pkg::CMD_RESTART, '1);
		push_load(mwss_pkg::CMD_LOAD_TOTAL, {5'd1, 5'd1}, '0, '1);
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd1, 5'd1}, 5'd0, {32'd0, 32'hFFFF_FFFF});
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd1, 5'd1}, 5'd1, '0);
		plan_draw('1);
		plan_draw('0);
		// zero total: first nonzero count wins
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd1, 5'd0}, 5'd0, '0);
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd1, 5'd0}, 5'd1, 64'd3);
		push_load(mwss_pkg::CMD_LOAD_TOTAL, {5'd1, 5'd0}, '0, '0);
		plan_draw($urandom);
		// corner indexes and zero values on otherwise unused entries
		push_load(mwss_pkg::CMD_LOAD_COUNT, {5'd0, 5'd31}, 5'd31, '0);
		push_load(mwss_pkg::CMD_LOAD_TOTAL, {5'd31, 5'd0}, 5'd0, '0);
		push_command(mwss_pkg::CMD_RESTART, '0);

		// Random phases, each behind a register write; extremes first.
		phase = 0;
		while (items_planned < ITEM_TARGET) begin
			setting = (phase < 5) ? extreme_settings[phase] : $urandom_range(63, 0);
			plan_alphabet(setting);
			// sometimes keep the old history across a size change
			if ($urandom_range(3, 0) != 0)
				push_command(mwss_pkg::CMD_RESTART, $urandom);
			favored_syms = '0;
			repeat ($urandom_range(4, 2))
				favored_syms[$urandom_range(alphabet_size(setting) - 1, 0)] = 1'b1;
			ops = $urandom_range(120, 40);
			while (ops != 0 && items_planned < ITEM_TARGET) begin
				plan_random_op();
				ops--;
			end
			phase++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || in_valid || cfg_valid || expected_draws.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_draws.size() != 0) begin
			$display("%0t: draw results expected %0d actual %0d",
				$time, results_seen + expected_draws.size(), results_seen);
			failures++;
		end

		$display("Ran %0d transactions in over %0d alphabet settings, incl. long receiver hold.",
			items_accepted, alphabet_writes);
		$display("Checked %0d drawn symbols, %0d of them past the end of the walk.",
			results_seen, past_end_seen);
		if (failures == 0)
			$display("markov_weighted_symbol_sampler_unit: match");
		else
			$display("markov_weighted_symbol_sampler_unit: mismatch");
		$finish;
	end

endmodule
